[rtl/polar_grid_bilinear_resampler_core_macros.svh]
// assertion macros for the polar grid resampler
`ifndef POLAR_GRID_BILINEAR_RESAMPLER_CORE_MACROS_SVH
`define POLAR_GRID_BILINEAR_RESAMPLER_CORE_MACROS_SVH

`ifndef SYNTH
// property that must hold at every clock edge out of reset
`define PGBR_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("pgbr assertion failed");
// condition that must never be true out of reset
`define PGBR_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("pgbr forbidden condition seen");
`else
`define PGBR_ASSERT(lbl, clk, rst_n, prop)
`define PGBR_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

[rtl/pgbr_pkg.sv]
package pgbr_pkg;

  localparam int unsigned MAX_RINGS_DEF   = 256;
  localparam int unsigned MAX_SECTORS_DEF = 512;
  localparam int unsigned NUM_W_DEF =
    $clog2(2 * MAX_SECTORS_DEF * MAX_SECTORS_DEF + 1024 * MAX_SECTORS_DEF) + 1;
  localparam int unsigned DIV_W_DEF = (NUM_W_DEF > 17) ? NUM_W_DEF : 17;

  localparam int unsigned IN_DATA_W  = 96;
  localparam int unsigned OUT_DATA_W = 56;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 10;

  // item kinds carried in tuser
  localparam logic [1:0] OP_LOAD_RADIUS = 2'd0;
  localparam logic [1:0] OP_LOAD_SAMPLE = 2'd1;
  localparam logic [1:0] OP_QUERY       = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OLD_RINGS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OLD_SECTORS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NEW_SECTORS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STAGGER     = 2'd3;

  localparam logic [16:0] Q_ONE = 17'h10000;

  typedef enum logic [1:0] {RD_FIRST, RD_LAST, RD_NEXT} rd_sel_e;
  typedef enum logic [1:0] {SRD_P00, SRD_P01, SRD_P10, SRD_P11} srd_sel_e;
  typedef enum logic [1:0] {DIV_FI, DIV_QUO, DIV_MOD, DIV_FJ} div_sel_e;
  typedef enum logic [1:0] {MAC_NONE, MAC_LOAD, MAC_ADD} mac_op_e;
  typedef enum logic [1:0] {SRC_SDATA, SRC_A0, SRC_A1} mac_src_e;
  typedef enum logic [1:0] {W_FJ_INV, W_FJ, W_FI_INV, W_FI} mac_w_e;

  typedef struct packed {
    logic     take;
    logic     start;
    rd_sel_e  rd_sel;
    logic     latch_t0;
    logic     latch_tl;
    logic     srch_chk;
    logic     frac_set;
    logic     div_go;
    logic     div_take;
    div_sel_e div_sel;
    logic     num_calc;
    logic     addr_calc;
    srd_sel_e srd_sel;
    mac_op_e  mac_op;
    mac_src_e mac_src;
    mac_w_e   mac_w;
    logic     latch_a0;
    logic     latch_a1;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic srch_more;
    logic fi_div;
    logic out_free;
  } dp_stat_t;

endpackage

[rtl/polar_grid_bilinear_resampler_core.sv]
// operation: load words are taken while no query is in flight; a query walks the ring
//   search, a ring-fraction divide when needed, the quotient, modulo and sector-fraction
//   divides (DIV_W = 21 at the default sizes) and the blend before its result is loaded
// one query at a time: the ring search uses the single radius-table read port and
//   the divider is bit-serial and shared
// reset: rst_ni is asynchronous active low; only control, config and valid registers reset
`include "polar_grid_bilinear_resampler_core_macros.svh"
module polar_grid_bilinear_resampler_core import pgbr_pkg::*; #(
  parameter int unsigned MAX_RINGS   = MAX_RINGS_DEF,
  parameter int unsigned MAX_SECTORS = MAX_SECTORS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // input words
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // load_index[16:0], load_value[48:17], new_radius[80:49], new_sector[89:81]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // op[1:0]
  input  logic [1:0]            s_axis_tuser,
  // result words
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // value[31:0], base_ring[39:32], base_sector[48:40]
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  logic [31:0] value;
  logic [7:0]  base_ring;
  logic [8:0]  base_sector;

  // controller walks each query through clamp, search, divides and blend
  pgbr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_op_i    (s_axis_tuser),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // datapath holds config, memories, divider and the blend accumulator
  pgbr_dp #(
    .MAX_RINGS   (MAX_RINGS),
    .MAX_SECTORS (MAX_SECTORS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (s_axis_tvalid),
    .in_op_i           (s_axis_tuser),
    .in_load_index_i   (s_axis_tdata[16:0]),
    .in_load_value_i   (s_axis_tdata[48:17]),
    .in_new_radius_i   (s_axis_tdata[80:49]),
    .in_new_sector_i   (s_axis_tdata[89:81]),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .out_ready_i       (m_axis_tready),
    .out_valid_o       (m_axis_tvalid),
    .out_value_o       (value),
    .out_base_ring_o   (base_ring),
    .out_base_sector_o (base_sector)
  );

  // ready only while no query is in flight; results wait in the output register
  assign s_axis_tready = cmd.take;
  assign m_axis_tdata  = {7'b0, base_sector, base_ring, value};

  // divider is never restarted mid-division
  `PGBR_ASSERT(a_div_go_idle, clk_i, rst_ni, stat.div_busy |-> !cmd.div_go)
  // a result is loaded only when the output register can take it
  `PGBR_ASSERT(a_out_load_free, clk_i, rst_ni, cmd.out_load |-> stat.out_free)
  // divider is quiet whenever new words are taken
  `PGBR_ASSERT(a_take_div_idle, clk_i, rst_ni, cmd.take |-> !stat.div_busy)
  // a quotient is never taken while the divider still runs
  `PGBR_NEVER(a_take_busy, clk_i, rst_ni, cmd.div_take && stat.div_busy)

endmodule

[rtl/pgbr_ctrl.sv]
module pgbr_ctrl import pgbr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] in_op_i,
  input  dp_stat_t   stat_i,
  output dp_cmd_t    cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_T0, S_TL, S_CLAMP, S_SRD, S_SCHK, S_FRAC, S_FI_W, S_NUM,
    S_QUO_GO, S_QUO_W, S_MOD_GO, S_MOD_W, S_FJ_GO, S_FJ_W, S_ADDR,
    S_RD00, S_RD01, S_RD10, S_RD11, S_B1, S_B2, S_B3, S_DONE
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        cmd_o.take = 1'b1;
        if (in_valid_i && in_op_i == OP_QUERY) begin
          cmd_o.start = 1'b1;
          state_d     = S_T0;
        end
      end
      S_T0: begin
        cmd_o.rd_sel = RD_FIRST;
        state_d      = S_TL;
      end
      S_TL: begin
        cmd_o.rd_sel   = RD_LAST;
        cmd_o.latch_t0 = 1'b1;
        state_d        = S_CLAMP;
      end
      S_CLAMP: begin
        cmd_o.latch_tl = 1'b1;
        state_d        = S_SRD;
      end
      S_SRD: begin
        cmd_o.rd_sel = RD_NEXT;
        state_d      = S_SCHK;
      end
      S_SCHK: begin
        cmd_o.srch_chk = 1'b1;
        state_d        = stat_i.srch_more ? S_SRD : S_FRAC;
      end
      S_FRAC: begin
        if (stat_i.fi_div) begin
          cmd_o.div_go  = 1'b1;
          cmd_o.div_sel = DIV_FI;
          state_d       = S_FI_W;
        end else begin
          cmd_o.frac_set = 1'b1;
          state_d        = S_NUM;
        end
      end
      S_FI_W: begin
        cmd_o.div_sel = DIV_FI;
        if (!stat_i.div_busy) begin
          cmd_o.div_take = 1'b1;
          state_d        = S_NUM;
        end
      end
      S_NUM: begin
        cmd_o.num_calc = 1'b1;
        state_d        = S_QUO_GO;
      end
      S_QUO_GO: begin
        cmd_o.div_go  = 1'b1;
        cmd_o.div_sel = DIV_QUO;
        state_d       = S_QUO_W;
      end
      S_QUO_W: begin
        cmd_o.div_sel = DIV_QUO;
        if (!stat_i.div_busy) begin
          cmd_o.div_take = 1'b1;
          state_d        = S_MOD_GO;
        end
      end
      S_MOD_GO: begin
        cmd_o.div_go  = 1'b1;
        cmd_o.div_sel = DIV_MOD;
        state_d       = S_MOD_W;
      end
      S_MOD_W: begin
        cmd_o.div_sel = DIV_MOD;
        if (!stat_i.div_busy) begin
          cmd_o.div_take = 1'b1;
          state_d        = S_FJ_GO;
        end
      end
      S_FJ_GO: begin
        cmd_o.div_go  = 1'b1;
        cmd_o.div_sel = DIV_FJ;
        state_d       = S_FJ_W;
      end
      S_FJ_W: begin
        cmd_o.div_sel = DIV_FJ;
        if (!stat_i.div_busy) begin
          cmd_o.div_take = 1'b1;
          state_d        = S_ADDR;
        end
      end
      S_ADDR: begin
        cmd_o.addr_calc = 1'b1;
        state_d         = S_RD00;
      end
      S_RD00: begin
        cmd_o.srd_sel = SRD_P00;
        state_d       = S_RD01;
      end
      S_RD01: begin
        cmd_o.srd_sel = SRD_P01;
        cmd_o.mac_op  = MAC_LOAD;
        cmd_o.mac_src = SRC_SDATA;
        cmd_o.mac_w   = W_FJ_INV;
        state_d       = S_RD10;
      end
      S_RD10: begin
        cmd_o.srd_sel = SRD_P10;
        cmd_o.mac_op  = MAC_ADD;
        cmd_o.mac_src = SRC_SDATA;
        cmd_o.mac_w   = W_FJ;
        state_d       = S_RD11;
      end
      S_RD11: begin
        cmd_o.srd_sel  = SRD_P11;
        cmd_o.latch_a0 = 1'b1;
        cmd_o.mac_op   = MAC_LOAD;
        cmd_o.mac_src  = SRC_SDATA;
        cmd_o.mac_w    = W_FJ_INV;
        state_d        = S_B1;
      end
      S_B1: begin
        cmd_o.mac_op  = MAC_ADD;
        cmd_o.mac_src = SRC_SDATA;
        cmd_o.mac_w   = W_FJ;
        state_d       = S_B2;
      end
      S_B2: begin
        cmd_o.latch_a1 = 1'b1;
        cmd_o.mac_op   = MAC_LOAD;
        cmd_o.mac_src  = SRC_A0;
        cmd_o.mac_w    = W_FI_INV;
        state_d        = S_B3;
      end
      S_B3: begin
        cmd_o.mac_op  = MAC_ADD;
        cmd_o.mac_src = SRC_A1;
        cmd_o.mac_w   = W_FI;
        state_d       = S_DONE;
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[rtl/pgbr_div.sv]
module pgbr_div import pgbr_pkg::*; #(
  parameter int unsigned DIV_W = DIV_W_DEF,
  localparam int unsigned CNT_W = $clog2(DIV_W + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [31:0]      rem_init_i,
  input  logic [DIV_W-1:0] dvd_i,
  input  logic [31:0]      den_i,
  input  logic [CNT_W-1:0] steps_i,
  output logic             busy_o,
  output logic [DIV_W-1:0] quo_o,
  output logic [31:0]      rem_o
);

  logic             busy_q;
  logic [CNT_W-1:0] cnt_q;
  logic [31:0]      rem_q, den_q;
  logic [DIV_W-1:0] dvd_q, quo_q;
  logic [32:0]      trial, diff;
  logic             ge;

  // one restoring step per cycle
  assign trial = {rem_q, dvd_q[DIV_W-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= steps_i;
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= rem_init_i;
      dvd_q <= dvd_i;
      den_q <= den_i;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? diff[31:0] : trial[31:0];
      dvd_q <= {dvd_q[DIV_W-2:0], 1'b0};
      quo_q <= {quo_q[DIV_W-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

[rtl/pgbr_dp.sv]
module pgbr_dp import pgbr_pkg::*; #(
  parameter int unsigned MAX_RINGS   = MAX_RINGS_DEF,
  parameter int unsigned MAX_SECTORS = MAX_SECTORS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  input  logic [1:0]            in_op_i,
  input  logic [16:0]           in_load_index_i,
  input  logic [31:0]           in_load_value_i,
  input  logic [31:0]           in_new_radius_i,
  input  logic [8:0]            in_new_sector_i,
  input  dp_cmd_t               cmd_i,
  output dp_stat_t              stat_o,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [31:0]           out_value_o,
  output logic [7:0]            out_base_ring_o,
  output logic [8:0]            out_base_sector_o
);

  localparam int unsigned RING_W = $clog2(MAX_RINGS);
  localparam int unsigned NR_W   = $clog2(MAX_RINGS + 1);
  localparam int unsigned SEC_W  = $clog2(MAX_SECTORS + 1);
  localparam int unsigned DEPTH  = MAX_RINGS * MAX_SECTORS;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned PW     = ADDR_W + 1;
  localparam int unsigned NUM_W  =
    $clog2(2 * MAX_SECTORS * MAX_SECTORS + 1024 * MAX_SECTORS) + 1;
  localparam int unsigned NUMS_W = NUM_W + 1;
  localparam int unsigned DIV_W  = (NUM_W > 17) ? NUM_W : 17;
  localparam int unsigned CNT_W  = $clog2(DIV_W + 1);
  localparam int unsigned ACC_W  = 52;

  // configuration
  logic [8:0] old_rings_q;
  logic [9:0] old_sectors_q, new_sectors_q;
  logic       stagger_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      old_rings_q   <= 9'd2;
      old_sectors_q <= 10'd1;
      new_sectors_q <= 10'd1;
      stagger_q     <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_OLD_RINGS:   old_rings_q   <= cfg_data_i[8:0];
        CFG_OLD_SECTORS: old_sectors_q <= cfg_data_i;
        CFG_NEW_SECTORS: new_sectors_q <= cfg_data_i;
        CFG_STAGGER:     stagger_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic [NR_W-1:0]  nr;
  logic [SEC_W-1:0] so, sn;

  assign nr = (old_rings_q < 9'd2) ? NR_W'(2) :
              (32'(old_rings_q) > MAX_RINGS) ? NR_W'(MAX_RINGS) : NR_W'(old_rings_q);
  assign so = (old_sectors_q == '0) ? SEC_W'(1) :
              (32'(old_sectors_q) > MAX_SECTORS) ? SEC_W'(MAX_SECTORS)
                                                 : SEC_W'(old_sectors_q);
  assign sn = (new_sectors_q == '0) ? SEC_W'(1) :
              (32'(new_sectors_q) > MAX_SECTORS) ? SEC_W'(MAX_SECTORS)
                                                 : SEC_W'(new_sectors_q);

  // input side
  logic        accept;
  logic [31:0] li32;

  assign accept = in_valid_i && cmd_i.take;
  assign li32   = 32'(in_load_index_i);

  logic [31:0] r_q;
  logic [8:0]  j_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      r_q <= in_new_radius_i;
      j_q <= in_new_sector_i;
    end
  end

  // ring radius table
  logic [31:0]       rtab [MAX_RINGS];
  logic [RING_W-1:0] raddr;
  logic [31:0]       rdat_q;
  logic [RING_W-1:0] ir_q;

  always_comb begin
    case (cmd_i.rd_sel)
      RD_FIRST: raddr = '0;
      RD_LAST:  raddr = RING_W'(nr - NR_W'(1));
      RD_NEXT:  raddr = ir_q + RING_W'(1);
      default:  raddr = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept && in_op_i == OP_LOAD_RADIUS && li32 < MAX_RINGS) begin
      rtab[li32[RING_W-1:0]] <= in_load_value_i;
    end
    rdat_q <= rtab[raddr];
  end

  // radius clamp, bracket search and ring fraction
  logic [31:0] t0_q, tl_q, rc_q, lo_q, hi_q, r_lo;
  logic [16:0] fi_q, fj_q;
  logic        srch_more, fi_div;

  assign r_lo      = (r_q < t0_q) ? t0_q : r_q;
  assign srch_more = (NR_W'(ir_q) < nr - NR_W'(2)) && (rdat_q <= rc_q);
  assign fi_div    = !(rc_q <= t0_q) && !(rc_q >= tl_q) && (hi_q > lo_q) && (rc_q >= lo_q);

  // sector position
  logic signed [NUMS_W-1:0]   num_q, num_w, num_d;
  logic signed [11:0]         jm;
  logic signed [12+SEC_W:0]   prod_num;
  logic [2*SEC_W-1:0]         snso;
  logic [2*SEC_W:0]           wrap_amt;
  logic [SEC_W-1:0]           sn_add;
  logic [31:0]                two_sn;

  assign jm       = $signed({2'b00, j_q, 1'b0}) - $signed({11'b0, stagger_q});
  assign prod_num = jm * $signed({1'b0, so});
  assign sn_add   = stagger_q ? sn : '0;
  assign num_d    = NUMS_W'(prod_num) + $signed(NUMS_W'(sn_add));
  assign snso     = sn * so;
  assign wrap_amt = {snso, 1'b0};
  assign num_w    = num_q[NUMS_W-1] ? num_q + $signed(NUMS_W'(wrap_amt)) : num_q;
  assign two_sn   = 32'({sn, 1'b0});

  // shared divider
  logic             div_busy;
  logic [DIV_W-1:0] div_quo, div_dvd, q_q;
  logic [31:0]      div_rem, div_rinit, div_den, nrem_q;
  logic [CNT_W-1:0] div_steps;
  logic [SEC_W-1:0] js_q;

  always_comb begin
    case (cmd_i.div_sel)
      DIV_FI: begin
        div_rinit = rc_q - lo_q;
        div_dvd   = '0;
        div_den   = hi_q - lo_q;
        div_steps = CNT_W'(16);
      end
      DIV_QUO: begin
        div_rinit = '0;
        div_dvd   = DIV_W'($unsigned(num_w));
        div_den   = two_sn;
        div_steps = CNT_W'(DIV_W);
      end
      DIV_MOD: begin
        div_rinit = '0;
        div_dvd   = q_q;
        div_den   = 32'(so);
        div_steps = CNT_W'(DIV_W);
      end
      DIV_FJ: begin
        div_rinit = nrem_q;
        div_dvd   = '0;
        div_den   = two_sn;
        div_steps = CNT_W'(16);
      end
      default: begin
        div_rinit = '0;
        div_dvd   = '0;
        div_den   = 32'd1;
        div_steps = CNT_W'(16);
      end
    endcase
  end

  pgbr_div #(.DIV_W(DIV_W)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_go),
    .rem_init_i (div_rinit),
    .dvd_i      (div_dvd),
    .den_i      (div_den),
    .steps_i    (div_steps),
    .busy_o     (div_busy),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_t0) begin
      t0_q <= rdat_q;
    end
    if (cmd_i.latch_tl) begin
      tl_q <= rdat_q;
      rc_q <= (r_lo > rdat_q) ? rdat_q : r_lo;
      lo_q <= t0_q;
      ir_q <= '0;
    end
    if (cmd_i.srch_chk) begin
      if (srch_more) begin
        ir_q <= ir_q + RING_W'(1);
        lo_q <= rdat_q;
      end else begin
        hi_q <= rdat_q;
      end
    end
    if (cmd_i.frac_set) begin
      if (rc_q <= t0_q) begin
        ir_q <= '0;
        fi_q <= '0;
      end else if (rc_q >= tl_q) begin
        ir_q <= RING_W'(nr - NR_W'(2));
        fi_q <= Q_ONE;
      end else begin
        fi_q <= '0;
      end
    end
    if (cmd_i.num_calc) begin
      num_q <= num_d;
    end
    if (cmd_i.div_take) begin
      case (cmd_i.div_sel)
        DIV_FI:  fi_q   <= (div_quo > DIV_W'(Q_ONE)) ? Q_ONE : div_quo[16:0];
        DIV_QUO: begin
          q_q    <= div_quo;
          nrem_q <= div_rem;
        end
        DIV_MOD: js_q   <= div_rem[SEC_W-1:0];
        DIV_FJ:  fj_q   <= div_quo[16:0];
        default: ;
      endcase
    end
  end

  // sample store and neighbor addresses
  logic [31:0]       store [DEPTH];
  logic [ADDR_W-1:0] p00_q, p01, p10, p11, saddr;
  logic [PW-1:0]     p00_w;
  logic              pwrap_q;
  logic [31:0]       sdat_q;

  assign p00_w = PW'(js_q) + PW'(ir_q) * PW'(so);
  assign p01   = pwrap_q ? p00_q + ADDR_W'(1) - ADDR_W'(so) : p00_q + ADDR_W'(1);
  assign p10   = p00_q + ADDR_W'(so);
  assign p11   = p01 + ADDR_W'(so);

  always_comb begin
    case (cmd_i.srd_sel)
      SRD_P00: saddr = p00_q;
      SRD_P01: saddr = p01;
      SRD_P10: saddr = p10;
      SRD_P11: saddr = p11;
      default: saddr = p00_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.addr_calc) begin
      p00_q   <= p00_w[ADDR_W-1:0];
      pwrap_q <= (js_q == so - SEC_W'(1));
    end
    if (accept && in_op_i == OP_LOAD_SAMPLE && li32 < DEPTH) begin
      store[li32[ADDR_W-1:0]] <= in_load_value_i;
    end
    sdat_q <= store[saddr];
  end

  // blend multiply-accumulate
  logic signed [32:0]      msrc, a0_q, a1_q;
  logic [16:0]             mw;
  logic signed [50:0]      prod;
  logic signed [ACC_W-1:0] acc_q, acc_r;
  logic signed [35:0]      rnd;
  logic [31:0]             v_sat;

  always_comb begin
    case (cmd_i.mac_src)
      SRC_SDATA: msrc = $signed({sdat_q[31], sdat_q});
      SRC_A0:    msrc = a0_q;
      SRC_A1:    msrc = a1_q;
      default:   msrc = '0;
    endcase
    case (cmd_i.mac_w)
      W_FJ_INV: mw = Q_ONE - fj_q;
      W_FJ:     mw = fj_q;
      W_FI_INV: mw = Q_ONE - fi_q;
      W_FI:     mw = fi_q;
      default:  mw = '0;
    endcase
  end

  assign prod  = msrc * $signed({1'b0, mw});
  // round half up then floor
  assign acc_r = acc_q + ACC_W'(32768);
  assign rnd   = $signed(acc_r[ACC_W-1:16]);
  assign v_sat = (rnd > 36'sd2147483647) ? 32'h7fff_ffff :
                 (rnd < -36'sd2147483648) ? 32'h8000_0000 : rnd[31:0];

  always_ff @(posedge clk_i) begin
    case (cmd_i.mac_op)
      MAC_LOAD: acc_q <= ACC_W'(prod);
      MAC_ADD:  acc_q <= acc_q + ACC_W'(prod);
      default: ;
    endcase
    if (cmd_i.latch_a0) begin
      a0_q <= rnd[32:0];
    end
    if (cmd_i.latch_a1) begin
      a1_q <= rnd[32:0];
    end
  end

  // output word register
  logic        out_valid_q;
  logic [31:0] out_value_q;
  logic [7:0]  out_ring_q;
  logic [8:0]  out_sector_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_value_q  <= v_sat;
      out_ring_q   <= 8'(ir_q);
      out_sector_q <= 9'(js_q);
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_value_o       = out_value_q;
  assign out_base_ring_o   = out_ring_q;
  assign out_base_sector_o = out_sector_q;

  assign stat_o.div_busy  = div_busy;
  assign stat_o.srch_more = srch_more;
  assign stat_o.fi_div    = fi_div;
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

endmodule
